// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CHM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CHM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CHM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/chm_pkg.sv =====
// shared types, constants and helpers of the convex hull block
package chm_pkg;
    localparam int MAX_POINTS  = 64;
    localparam int COORD_BITS  = 16;
    localparam int CNT_W       = $clog2(MAX_POINTS + 2);
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int SIDX_W      = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        point_t pt;
        logic   store;
        logic   last;
        logic   ovf;
    } q_item_t;

    typedef struct packed {
        logic idle;
        logic emitting;
    } chm_status_t;

    function automatic logic pt_less(input point_t a, input point_t b);
        pt_less = (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
    endfunction
endpackage

// ===== rtl/convex_hull_monotone_chain.sv =====
// Convex hull of a point set by the monotone chain method. Points go in one per transfer
// and a queue of four entries lets the front end keep taking them while the hull engine
// works. Each stored point is placed in sorted order by an insertion pass over the point
// memory, one shift per cycle. After the final point the engine walks the sorted set
// twice; each point is fetched from the point memory and, while the stack holds enough
// points above the base of the pass, put through turn tests (depth check, two stack
// memory reads, one multiply stage, one compare), and each hull vertex then leaves
// through an output register, where it is held until out_ready takes it.
// Sets of more than 64 points keep the first 64 and flag every vertex as dropped.
`include "assert_macros.svh"
module convex_hull_monotone_chain (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [chm_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [chm_pkg::COORD_BITS-1:0] point_y,
    input  logic set_last,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [chm_pkg::COORD_BITS-1:0] vertex_x,
    output logic signed [chm_pkg::COORD_BITS-1:0] vertex_y,
    output logic hull_last,
    output logic points_dropped
);
    import chm_pkg::*;

    logic        q_push, q_full, q_pop, q_valid;
    q_item_t     q_in, q_head;
    chm_status_t status;

    chm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .point_x  (point_x),
        .point_y  (point_y),
        .set_last (set_last),
        .q_push   (q_push),
        .q_item   (q_in),
        .q_full   (q_full)
    );

    chm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    chm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .vertex_x       (vertex_x),
        .vertex_y       (vertex_y),
        .hull_last      (hull_last),
        .points_dropped (points_dropped),
        .status         (status)
    );

    `CHM_ASSERT_IMP(a_out_only_emitting, clk, rst_n, out_valid, status.emitting)
    `CHM_ASSERT_IMP(a_pop_only_idle, clk, rst_n, q_pop, status.idle && q_valid)
    `CHM_ASSERT_NXT(a_idle_after_set, clk, rst_n, out_valid && out_ready && hull_last, status.idle)
endmodule

// ===== rtl/chm_front.sv =====
// front end: takes points, decides store or drop and tracks overflow per set
module chm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic signed [chm_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [chm_pkg::COORD_BITS-1:0] point_y,
    input  logic             set_last,
    output logic             q_push,
    output chm_pkg::q_item_t q_item,
    input  logic             q_full
);
    import chm_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             store;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;
    assign store    = (count_reg < CNT_W'(MAX_POINTS));

    always_comb
    begin
        q_item.pt.x  = point_x;
        q_item.pt.y  = point_y;
        q_item.store = store;
        q_item.last  = set_last;
        q_item.ovf   = ovf_reg || !store;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        if (q_push)
        begin
            if (set_last)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = count_reg + CNT_W'(store);
                ovf_next   = ovf_reg || !store;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end
endmodule

// ===== rtl/chm_queue.sv =====
// short queue between front end and hull engine
module chm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  chm_pkg::q_item_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output chm_pkg::q_item_t head
);
    import chm_pkg::*;

    q_item_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg + QPTR_W'(push);
        rd_next  = rd_reg + QPTR_W'(pop);
        cnt_next = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end
endmodule

// ===== rtl/chm_back.sv =====
// hull engine: sorted point store, monotone chain stack and vertex output
module chm_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  chm_pkg::q_item_t q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic signed [chm_pkg::COORD_BITS-1:0] vertex_x,
    output logic signed [chm_pkg::COORD_BITS-1:0] vertex_y,
    output logic             hull_last,
    output logic             points_dropped,
    output chm_pkg::chm_status_t status
);
    import chm_pkg::*;

    typedef enum logic [18:0] {
        ST_IDLE    = 19'h00001,
        ST_INS_CMP = 19'h00002,
        ST_INS_PUT = 19'h00004,
        ST_HSTART  = 19'h00008,
        ST_SINGLE  = 19'h00010,
        ST_HFETCH  = 19'h00020,
        ST_HGETP   = 19'h00040,
        ST_HTEST   = 19'h00080,
        ST_HRDA    = 19'h00100,
        ST_HRDB    = 19'h00200,
        ST_HMUL    = 19'h00400,
        ST_HCMP    = 19'h00800,
        ST_HNEXT   = 19'h01000,
        ST_FIN     = 19'h02000,
        ST_FIN0    = 19'h04000,
        ST_FIN1    = 19'h08000,
        ST_EMSTART = 19'h10000,
        ST_EMLOAD  = 19'h20000,
        ST_EMWAIT  = 19'h40000
    } state_t;

    state_t state_reg, state_next;

    point_t pts_mem [MAX_POINTS];
    point_t st_mem  [MAX_POINTS+1];
    point_t pts_rd_reg, st_rd_reg;

    logic [IDX_W-1:0]  pts_raddr, pts_waddr;
    logic              pts_we;
    point_t            pts_wdata;
    logic [SIDX_W-1:0] st_raddr, st_waddr;
    logic              st_we;
    point_t            st_wdata;

    logic [CNT_W-1:0] n_reg, n_next, j_reg, j_next;
    logic [CNT_W-1:0] t_reg, t_next, s_reg, s_next, i_reg, i_next;
    logic [CNT_W-1:0] h_reg, h_next, k_reg, k_next, tdec;
    logic             pass_reg, pass_next, last_reg, last_next, ovf_reg, ovf_next;
    point_t           new_reg, new_next, p_reg, p_next, a_reg, a_next, b_reg, b_next;
    logic signed [PROD_W-1:0] l_reg, r_reg;
    logic signed [DIFF_W-1:0] dx1, dy1, dx2, dy2;
    logic             ov_reg, ov_next;
    point_t           ovp_reg, ovp_next;
    logic             ol_reg, ol_next, od_reg, od_next;

    assign out_valid       = ov_reg;
    assign vertex_x        = ovp_reg.x;
    assign vertex_y        = ovp_reg.y;
    assign hull_last       = ol_reg;
    assign points_dropped  = od_reg;
    assign status.idle     = (state_reg == ST_IDLE);
    assign status.emitting = (state_reg == ST_EMLOAD) || (state_reg == ST_EMWAIT);

    assign dx1  = DIFF_W'(b_reg.x) - DIFF_W'(a_reg.x);
    assign dy1  = DIFF_W'(b_reg.y) - DIFF_W'(a_reg.y);
    assign dx2  = DIFF_W'(p_reg.x) - DIFF_W'(a_reg.x);
    assign dy2  = DIFF_W'(p_reg.y) - DIFF_W'(a_reg.y);
    assign tdec = (t_reg != '0) ? t_reg - CNT_W'(1) : t_reg;

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg; j_next = j_reg; t_next = t_reg; s_next = s_reg;
        i_next = i_reg; h_next = h_reg; k_next = k_reg;
        pass_next = pass_reg; last_next = last_reg; ovf_next = ovf_reg;
        new_next = new_reg; p_next = p_reg; a_next = a_reg; b_next = b_reg;
        ov_next = ov_reg; ovp_next = ovp_reg; ol_next = ol_reg; od_next = od_reg;
        q_pop = 1'b0;
        pts_raddr = '0; pts_we = 1'b0; pts_waddr = '0; pts_wdata = new_reg;
        st_raddr = '0; st_we = 1'b0; st_waddr = '0; st_wdata = p_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    last_next = q_head.last;
                    ovf_next  = q_head.ovf;
                    new_next  = q_head.pt;
                    if (q_head.store)
                    begin
                        if (n_reg == '0)
                        begin
                            pts_we     = 1'b1;
                            pts_waddr  = '0;
                            pts_wdata  = q_head.pt;
                            n_next     = CNT_W'(1);
                            state_next = q_head.last ? ST_HSTART : ST_IDLE;
                        end
                        else
                        begin
                            j_next     = n_reg;
                            pts_raddr  = IDX_W'(n_reg - CNT_W'(1));
                            state_next = ST_INS_CMP;
                        end
                    end
                    else if (q_head.last)
                    begin
                        state_next = ST_HSTART;
                    end
                end
            end
            // one shift of the insertion sort per cycle
            ST_INS_CMP:
            begin
                if (pt_less(new_reg, pts_rd_reg))
                begin
                    pts_we    = 1'b1;
                    pts_waddr = IDX_W'(j_reg);
                    pts_wdata = pts_rd_reg;
                    j_next    = j_reg - CNT_W'(1);
                    if (j_reg == CNT_W'(1))
                    begin
                        state_next = ST_INS_PUT;
                    end
                    else
                    begin
                        pts_raddr = IDX_W'(j_reg - CNT_W'(2));
                    end
                end
                else
                begin
                    pts_we     = 1'b1;
                    pts_waddr  = IDX_W'(j_reg);
                    pts_wdata  = new_reg;
                    n_next     = n_reg + CNT_W'(1);
                    state_next = last_reg ? ST_HSTART : ST_IDLE;
                end
            end
            ST_INS_PUT:
            begin
                pts_we     = 1'b1;
                pts_waddr  = '0;
                pts_wdata  = new_reg;
                n_next     = n_reg + CNT_W'(1);
                state_next = last_reg ? ST_HSTART : ST_IDLE;
            end
            ST_HSTART:
            begin
                t_next    = '0;
                s_next    = '0;
                i_next    = '0;
                pass_next = 1'b0;
                pts_raddr = '0;
                state_next = (n_reg == CNT_W'(1)) ? ST_SINGLE : ST_HFETCH;
            end
            ST_SINGLE:
            begin
                st_we      = 1'b1;
                st_waddr   = '0;
                st_wdata   = pts_rd_reg;
                t_next     = CNT_W'(1);
                state_next = ST_EMSTART;
            end
            ST_HFETCH:
            begin
                pts_raddr  = pass_reg ? IDX_W'(n_reg - CNT_W'(1) - i_reg) : IDX_W'(i_reg);
                state_next = ST_HGETP;
            end
            ST_HGETP:
            begin
                p_next     = pts_rd_reg;
                state_next = ST_HTEST;
            end
            ST_HTEST:
            begin
                if ({1'b0, t_reg} >= ({1'b0, s_reg} + (CNT_W+1)'(2)))
                begin
                    st_raddr   = SIDX_W'(t_reg - CNT_W'(2));
                    state_next = ST_HRDA;
                end
                else
                begin
                    if (t_reg < CNT_W'(MAX_POINTS + 1))
                    begin
                        st_we    = 1'b1;
                        st_waddr = SIDX_W'(t_reg);
                        t_next   = t_reg + CNT_W'(1);
                    end
                    state_next = ST_HNEXT;
                end
            end
            ST_HRDA:
            begin
                a_next     = st_rd_reg;
                st_raddr   = SIDX_W'(t_reg - CNT_W'(1));
                state_next = ST_HRDB;
            end
            ST_HRDB:
            begin
                b_next     = st_rd_reg;
                state_next = ST_HMUL;
            end
            ST_HMUL:
            begin
                state_next = ST_HCMP;
            end
            // pop while the turn is not strictly counterclockwise
            ST_HCMP:
            begin
                if (l_reg <= r_reg)
                begin
                    t_next     = t_reg - CNT_W'(1);
                    state_next = ST_HTEST;
                end
                else
                begin
                    if (t_reg < CNT_W'(MAX_POINTS + 1))
                    begin
                        st_we    = 1'b1;
                        st_waddr = SIDX_W'(t_reg);
                        t_next   = t_reg + CNT_W'(1);
                    end
                    state_next = ST_HNEXT;
                end
            end
            ST_HNEXT:
            begin
                if (i_reg == n_reg - CNT_W'(1))
                begin
                    t_next = tdec;
                    s_next = tdec;
                    i_next = '0;
                    if (!pass_reg)
                    begin
                        pass_next  = 1'b1;
                        state_next = ST_HFETCH;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_HFETCH;
                end
            end
            ST_FIN:
            begin
                st_raddr   = '0;
                state_next = (t_reg == CNT_W'(2)) ? ST_FIN0 : ST_EMSTART;
            end
            ST_FIN0:
            begin
                a_next     = st_rd_reg;
                st_raddr   = SIDX_W'(1);
                state_next = ST_FIN1;
            end
            // two identical survivors collapse to one vertex
            ST_FIN1:
            begin
                if (st_rd_reg == a_reg)
                begin
                    t_next = CNT_W'(1);
                end
                state_next = ST_EMSTART;
            end
            ST_EMSTART:
            begin
                h_next     = (t_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : t_reg;
                k_next     = '0;
                st_raddr   = '0;
                state_next = ST_EMLOAD;
            end
            ST_EMLOAD:
            begin
                ov_next    = 1'b1;
                ovp_next   = st_rd_reg;
                ol_next    = (k_reg + CNT_W'(1) == h_reg);
                od_next    = ovf_reg;
                state_next = ST_EMWAIT;
            end
            ST_EMWAIT:
            begin
                if (out_ready)
                begin
                    ov_next = 1'b0;
                    if (ol_reg)
                    begin
                        n_next     = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        st_raddr   = SIDX_W'(k_reg + CNT_W'(1));
                        state_next = ST_EMLOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        t_reg    <= t_next;
        s_reg    <= s_next;
        i_reg    <= i_next;
        h_reg    <= h_next;
        k_reg    <= k_next;
        pass_reg <= pass_next;
        last_reg <= last_next;
        new_reg  <= new_next;
        p_reg    <= p_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        ovp_reg  <= ovp_next;
        ol_reg   <= ol_next;
        od_reg   <= od_next;
        l_reg    <= dx1 * dy2;
        r_reg    <= dy1 * dx2;
    end

    always_ff @(posedge clk)
    begin
        if (pts_we)
        begin
            pts_mem[pts_waddr] <= pts_wdata;
        end
        pts_rd_reg <= pts_mem[pts_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        st_rd_reg <= st_mem[st_raddr];
    end
endmodule
